@@ rtl/core/dcc_pkg.sv @@
package dcc_pkg;

  // field widths
  localparam int DateW    = 27;
  localparam int CountW   = 23;
  localparam int DayW     = 7;
  localparam int YearW    = 14;
  localparam int JdW      = 24;
  localparam int SumW     = 25;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMonthBasis = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgYearBasis  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEomRule    = 2'd2;

  // month basis codes
  localparam logic MbThirty = 1'b0;
  localparam logic MbActual = 1'b1;

  // year basis codes
  localparam logic [1:0] YbUs360  = 2'd0;
  localparam logic [1:0] YbUs365  = 2'd1;
  localparam logic [1:0] YbEuro   = 2'd2;
  localparam logic [1:0] YbActual = 2'd3;

  // saturation limits of the day count
  localparam logic signed [SumW-1:0] CountMax = 25'sd4000000;
  localparam logic signed [SumW-1:0] CountMin = -25'sd4000000;

  typedef struct packed {
    logic       mb;
    logic [1:0] yb;
    logic       eom;
  } cfg_t;

  // one date after unpacking, with its julian day number
  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [DayW-1:0]  month;
    logic [YearW-1:0] year;
    logic             leap;
    logic             bad;
    logic [JdW-1:0]   jd;
  } date_t;

  // month term of the julian day number, march-based year
  function automatic logic [8:0] month_offset(input logic [DayW-1:0] m);
    logic [8:0] r;
    case (m)
      7'd1:    r = 9'd336;
      7'd2:    r = 9'd367;
      7'd3:    r = 9'd30;
      7'd4:    r = 9'd61;
      7'd5:    r = 9'd91;
      7'd6:    r = 9'd122;
      7'd7:    r = 9'd152;
      7'd8:    r = 9'd183;
      7'd9:    r = 9'd214;
      7'd10:   r = 9'd244;
      7'd11:   r = 9'd275;
      7'd12:   r = 9'd305;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/dcc_in_if.sv @@
interface dcc_in_if;
  import dcc_pkg::*;

  logic             valid;
  logic             ready;
  logic [DateW-1:0] first_date;
  logic [DateW-1:0] second_date;

  modport source (output valid, first_date, second_date, input ready);
  modport sink   (input valid, first_date, second_date, output ready);
endinterface

@@ rtl/core/dcc_out_if.sv @@
interface dcc_out_if;
  import dcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] day_count;
  logic              bad_date;

  modport source (output valid, day_count, bad_date, input ready);
  modport sink   (input valid, day_count, bad_date, output ready);
endinterface

@@ rtl/core/dcc_date_unpack.sv @@
module dcc_date_unpack (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [dcc_pkg::DateW-1:0]   date_i,
  output dcc_pkg::date_t              date_o
);
  import dcc_pkg::*;

  // reciprocals of 100 for the three digit splits
  localparam int              Q1W   = 21;
  localparam int              Sh1   = 34;
  localparam logic [27:0]     Mul1  = 28'd171798692;
  localparam int              Sh2   = 28;
  localparam logic [21:0]     Mul2  = 22'd2684355;
  localparam int              CentW = 8;
  localparam int              Sh3   = 21;
  localparam logic [14:0]     Mul3  = 15'd20972;

  // stage 1: packed date / 100
  logic [54:0]      p1;
  logic [Q1W-1:0]   q1_d, q1_q;
  logic [DayW-1:0]  xl_q;

  assign p1   = 55'(date_i) * 55'(Mul1);
  assign q1_d = p1[Sh1+Q1W-1:Sh1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q <= q1_d;
      xl_q <= date_i[DayW-1:0];
    end
  end

  // stage 2: day digits, year = (date / 100) / 100
  logic [27:0]      q1x100;
  logic [42:0]      p2;
  logic [DayW-1:0]  d2_d, d2_q;
  logic [YearW-1:0] y2_d, y2_q;
  logic [DayW-1:0]  ql_q;

  assign q1x100 = 28'(q1_q) * 28'd100;
  assign d2_d   = xl_q - q1x100[DayW-1:0];
  assign p2     = 43'(q1_q) * 43'(Mul2);
  assign y2_d   = p2[Sh2+YearW-1:Sh2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q <= d2_d;
      y2_q <= y2_d;
      ql_q <= q1_q[DayW-1:0];
    end
  end

  // stage 3: month digits, century of the year
  logic [YearW+6:0] yx100;
  logic [28:0]      p3;
  logic [DayW-1:0]  m3_d, m3_q, d3_q;
  logic [YearW-1:0] y3_q;
  logic [CentW-1:0] yc_d, yc_q;

  assign yx100 = 21'(y2_q) * 21'd100;
  assign m3_d  = ql_q - yx100[DayW-1:0];
  assign p3    = 29'(y2_q) * 29'(Mul3);
  assign yc_d  = p3[Sh3+CentW-1:Sh3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_q <= m3_d;
      d3_q <= d2_q;
      y3_q <= y2_q;
      yc_q <= yc_d;
    end
  end

  // stage 4: range check, leap year, julian terms
  logic [14:0]      ycx100;
  logic [DayW-1:0]  ymod;
  logic             early;
  logic             leap_d;
  logic             bad_d;
  logic [CentW-1:0] cent_d, cent_q;
  logic [14:0]      ya;
  logic [24:0]      t1p;
  logic [22:0]      t1_q;
  logic [8:0]       t2_q;
  logic [DayW-1:0]  d4_q, m4_q;
  logic [YearW-1:0] y4_q;
  logic             leap_q, bad_q;

  assign ycx100 = 15'(yc_q) * 15'd100;
  assign ymod   = y3_q[DayW-1:0] - ycx100[DayW-1:0];
  assign early  = (m3_q <= 7'd2);
  assign leap_d = (y3_q[1:0] == 2'd0) && !((ymod == 7'd0) && (yc_q[1:0] != 2'd0));
  assign bad_d  = (m3_q < 7'd1) || (m3_q > 7'd12) || (d3_q < 7'd1) || (d3_q > 7'd31);
  // (y + 4900 - a) / 100 from the century, one lower when a january or
  // february date sits on a whole century
  assign cent_d = yc_q + 8'd49 - {7'd0, early && (ymod == 7'd0)};
  assign ya     = 15'(y3_q) + 15'd4800 - {14'd0, early};
  assign t1p    = 25'(ya) * 25'd1461;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cent_q <= cent_d;
      t1_q   <= t1p[24:2];
      t2_q   <= month_offset(m3_q);
      d4_q   <= d3_q;
      m4_q   <= m3_q;
      y4_q   <= y3_q;
      leap_q <= leap_d;
      bad_q  <= bad_d;
    end
  end

  // stage 5: julian day number
  logic [9:0]     c3;
  logic [JdW-1:0] jd_d;

  assign c3   = {2'b00, cent_q} + {1'b0, cent_q, 1'b0};
  assign jd_d = 24'(d4_q) + 24'(t1_q) + 24'(t2_q) - 24'd32075 - 24'(c3[9:2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      date_o.day   <= d4_q;
      date_o.month <= m4_q;
      date_o.year  <= y4_q;
      date_o.leap  <= leap_q;
      date_o.bad   <= bad_q;
      date_o.jd    <= jd_d;
    end
  end

endmodule

@@ rtl/core/dcc_count.sv @@
module dcc_count (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  dcc_pkg::cfg_t               cfg_i,
  input  dcc_pkg::date_t              lo_i,
  input  dcc_pkg::date_t              hi_i,
  output logic [dcc_pkg::CountW-1:0]  day_count_o,
  output logic                        bad_date_o
);
  import dcc_pkg::*;

  // stage 1: day adjustments and differences
  logic            f1, f2;
  logic [DayW-1:0] d1a, d2a, d1u, d2u, d1e, d2e;
  logic [SumW-1:0] act_d;
  logic [7:0]      md_d;

  assign f1 = (lo_i.month == 7'd2) && (lo_i.day == (lo_i.leap ? 7'd29 : 7'd28));
  assign f2 = (hi_i.month == 7'd2) && (hi_i.day == (hi_i.leap ? 7'd29 : 7'd28));

  // us rule: february end of month first, then 31 to 30
  assign d2a = (cfg_i.eom && f1 && f2) ? 7'd30 : hi_i.day;
  assign d1a = (cfg_i.eom && f1) ? 7'd30 : lo_i.day;
  assign d2u = ((d2a == 7'd31) && (d1a >= 7'd30)) ? 7'd30 : d2a;
  assign d1u = (d1a == 7'd31) ? 7'd30 : d1a;

  // european rule: both days clamp to 30
  assign d1e = (lo_i.day == 7'd31) ? 7'd30 : lo_i.day;
  assign d2e = (hi_i.day == 7'd31) ? 7'd30 : hi_i.day;

  assign act_d = {1'b0, hi_i.jd} - {1'b0, lo_i.jd};
  assign md_d  = {1'b0, hi_i.month} - {1'b0, lo_i.month};

  logic [SumW-1:0]  act_q;
  logic [DayW-1:0]  d1u_q, d2u_q, d1e_q, d2e_q;
  logic [YearW-1:0] yd_q;
  logic [7:0]       md_q;
  logic             bad1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_q  <= act_d;
      d1u_q  <= d1u;
      d2u_q  <= d2u;
      d1e_q  <= d1e;
      d2e_q  <= d2e;
      yd_q   <= hi_i.year - lo_i.year;
      md_q   <= md_d;
      bad1_q <= lo_i.bad | hi_i.bad;
    end
  end

  // stage 2: thirty-day sums and convention select
  logic [SumW-1:0] ym, us, eu, sel_d, cnt_q;
  logic            bad2_q;

  assign ym = 25'(yd_q) * 25'd360 + {{(SumW-8){md_q[7]}}, md_q} * 25'd30;
  assign us = ym + 25'(d2u_q) - 25'(d1u_q);
  assign eu = ym + 25'(d2e_q) - 25'(d1e_q);

  always_comb begin
    sel_d = '0;
    if (bad1_q) begin
      sel_d = '0;
    end else if (cfg_i.mb == MbActual) begin
      sel_d = act_q;
    end else begin
      case (cfg_i.yb) inside
        YbUs360, YbUs365: sel_d = us;
        YbEuro:           sel_d = eu;
        default:          sel_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cnt_q  <= sel_d;
      bad2_q <= bad1_q;
    end
  end

  // stage 3: saturate to the output range
  logic signed [SumW-1:0] cnt_s, sat;

  assign cnt_s = $signed(cnt_q);

  always_comb begin
    if (cnt_s > CountMax) begin
      sat = CountMax;
    end else if (cnt_s < CountMin) begin
      sat = CountMin;
    end else begin
      sat = cnt_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      day_count_o <= sat[CountW-1:0];
      bad_date_o  <= bad2_q;
    end
  end

endmodule

@@ rtl/core/day_count_convention.sv @@
// channel   | role   | payload
// ----------+--------+-------------------------------------------
// in_i      | sink   | first_date[26:0], second_date[26:0]
// out_o     | source | day_count[22:0] (two's complement), bad_date
// cfg_*     | write  | cfg_idx_i selects, cfg_wdata_i[1:0] data
//
// nine register stages: order, five for date unpacking and the julian
// number, three for the count; one pair is taken every cycle while the
// last stage is empty or out_o is ready.
// the whole pipeline holds while a result waits on out_o, so nothing
// is dropped or repeated; empty stages fill while the output is free.
// rst_ni clears the stage valid bits and loads the register defaults.
module day_count_convention (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dcc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  dcc_in_if.sink                        in_i,
  dcc_out_if.source                     out_o
);
  import dcc_pkg::*;

  localparam int Stages = 9;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mb  <= MbThirty;
      cfg_q.yb  <= YbUs360;
      cfg_q.eom <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMonthBasis: cfg_q.mb  <= cfg_wdata_i[0];
        CfgYearBasis:  cfg_q.yb  <= cfg_wdata_i[1:0];
        CfgEomRule:    cfg_q.eom <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished result is stalled
  logic              adv;
  logic [Stages-1:0] v_q;

  assign adv         = !v_q[Stages-1] || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = v_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Stages-2:0], in_i.valid};
    end
  end

  // order stage: earlier packed date first
  logic [DateW-1:0] lo_q, hi_q;
  logic             swap;

  assign swap = in_i.second_date > in_i.first_date;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q <= swap ? in_i.first_date  : in_i.second_date;
      hi_q <= swap ? in_i.second_date : in_i.first_date;
    end
  end

  // date unpacking, one unit per date
  date_t lo_date, hi_date;

  dcc_date_unpack u_unpack_lo (
    .clk_i  (clk_i),
    .en_i   (adv),
    .date_i (lo_q),
    .date_o (lo_date)
  );

  dcc_date_unpack u_unpack_hi (
    .clk_i  (clk_i),
    .en_i   (adv),
    .date_i (hi_q),
    .date_o (hi_date)
  );

  // convention arithmetic and output register
  dcc_count u_count (
    .clk_i       (clk_i),
    .en_i        (adv),
    .cfg_i       (cfg_q),
    .lo_i        (lo_date),
    .hi_i        (hi_date),
    .day_count_o (out_o.day_count),
    .bad_date_o  (out_o.bad_date)
  );

endmodule
